// ----- rtl/account_receipt_checker_unit_macros.svh -----
// Assertion macros for the account receipt checker.
`ifndef ACCOUNT_RECEIPT_CHECKER_UNIT_MACROS_SVH
`define ACCOUNT_RECEIPT_CHECKER_UNIT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ARC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ARC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/arc_pkg.sv -----
// Shared types and codes of the account receipt checker.
package arc_pkg;
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0, OP_LOAD = 2'd1, OP_ITEM = 2'd2, OP_RCPT = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_ORDER = 4'd1, ERR_COORD = 4'd2, ERR_NOCKPT = 4'd3,
    ERR_HOLE = 4'd4, ERR_KEY = 4'd5, ERR_ACCT = 4'd6, ERR_SEQ = 4'd7,
    ERR_PRE = 4'd8, ERR_TIME = 4'd9
  } err_e;

  localparam int unsigned InWidth  = 2 + 64 + 64 + 7 + 64 + 64 + 6 + 32 + 64 * 4;
  localparam int unsigned InBytes  = (InWidth + 7) / 8;
  localparam int unsigned OutWidth = 4 + 16 + 17 + 1;
  localparam int unsigned OutBytes = (OutWidth + 7) / 8;
endpackage

// ----- rtl/arc_slot_mem.sv -----
// Checkpoint memory: one write port, one registered read port.
module arc_slot_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/account_receipt_checker_unit.sv -----
// Account receipt checker: one status beat out for every beat in.
// Takes one beat per cycle, back to back. Each beat goes through two stages:
// stage one issues the checkpoint memory read, stage two checks the beat
// against the read data and writes the checkpoint back; its result is then
// registered in the two-entry output queue. A write in stage two is
// forwarded to a read of the same slot in stage one, so consecutive beats
// to one account see each other's updates. The input stalls only when the
// beat in stage two and the two-entry output queue would overflow because
// the output side is not taking results.
`include "account_receipt_checker_unit_macros.svh"
module account_receipt_checker_unit #(
  parameter int unsigned ACCOUNT_SLOTS = 64,
  parameter int unsigned HASH_BITS     = 64,
  parameter int unsigned MAX_ITEMS     = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // operation, key_lt, key_hash, account_slot, receipt_key_lt, receipt_key_hash,
  // receipt_account_slot, sequence_req, pre_state_hash, post_state_hash,
  // start_lt, end_lt
  input  logic [arc_pkg::InBytes*8-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // error_code, error_index, verified_count, failed
  output logic [arc_pkg::OutBytes*8-1:0]  m_axis_tdata
);
  localparam int unsigned SlotW = $clog2(ACCOUNT_SLOTS);
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EntW  = HASH_BITS + 32 + 64;
  localparam logic [63:0] HMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - HASH_BITS);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] klt;
    logic [63:0] khash;
    logic [6:0]  slot;
    logic [63:0] rklt;
    logic [63:0] rkhash;
    logic [5:0]  rslot;
    logic [31:0] seq;
    logic [63:0] pre;
    logic [63:0] post;
    logic [63:0] st;
    logic [63:0] en;
  } beat_t;

  beat_t in_b;
  assign in_b.op     = s_axis_tdata[1:0];
  assign in_b.klt    = s_axis_tdata[65:2];
  assign in_b.khash  = s_axis_tdata[129:66];
  assign in_b.slot   = s_axis_tdata[136:130];
  assign in_b.rklt   = s_axis_tdata[200:137];
  assign in_b.rkhash = s_axis_tdata[264:201];
  assign in_b.rslot  = s_axis_tdata[270:265];
  assign in_b.seq    = s_axis_tdata[302:271];
  assign in_b.pre    = s_axis_tdata[366:303];
  assign in_b.post   = s_axis_tdata[430:367];
  assign in_b.st     = s_axis_tdata[494:431];
  assign in_b.en     = s_axis_tdata[558:495];

  // Pipeline control: stage two result into a two-entry output queue
  logic        s2_vld_q;
  beat_t       s2_q;
  logic [1:0]  oq_cnt_q;
  logic        in_fire, out_fire;
  logic [arc_pkg::OutWidth-1:0] oq_q [2];
  logic [arc_pkg::OutWidth-1:0] res;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  // Room for the beat in flight plus the new one
  assign s_axis_tready = (oq_cnt_q + {1'b0, s2_vld_q}) < 2'd2 ||
                         (out_fire && oq_cnt_q + {1'b0, s2_vld_q} == 2'd2);
  assign m_axis_tvalid = oq_cnt_q != 2'd0;
  assign m_axis_tdata  = {{(arc_pkg::OutBytes*8-arc_pkg::OutWidth){1'b0}}, oq_q[0]};

  // Checkpoint memory and forwarding
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [EntW-1:0]  mem_wdata, mem_rdata, ent;
  logic             fwd_q;
  logic [EntW-1:0]  fwd_data_q;

  arc_slot_mem #(.Depth(ACCOUNT_SLOTS), .Width(EntW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (SlotW'(in_b.slot)),
    .rdata_o (mem_rdata)
  );

  assign ent = fwd_q ? fwd_data_q : mem_rdata;

  // Set state
  logic [ACCOUNT_SLOTS-1:0] valid_q, hole_q;
  logic [63:0]      prev_lt_q, prev_hash_q;
  logic             have_prev_q, ofault_q;
  logic [CntW-1:0]  items_q, verified_q;
  logic [15:0]      ofault_idx_q, ferr_idx_q;
  arc_pkg::err_e    ferr_q;

  logic [HASH_BITS-1:0] e_hash;
  logic [31:0]          e_seq;
  logic [63:0]          e_end;
  assign e_hash = ent[EntW-1 -: HASH_BITS];
  assign e_seq  = ent[95:64];
  assign e_end  = ent[63:0];

  logic             s_in_rng;
  logic [SlotW-1:0] s_slot;
  logic [63:0]      k_hash;
  arc_pkg::err_e    rc_err;
  assign s_in_rng = {25'd0, s2_q.slot} < 32'(ACCOUNT_SLOTS);
  assign s_slot   = SlotW'(s2_q.slot);
  assign k_hash   = s2_q.khash & HMask;

  // Receipt checks in priority order
  always_comb begin
    priority if (hole_q[s_slot])                         rc_err = arc_pkg::ERR_HOLE;
    else if (s2_q.rklt != s2_q.klt || (s2_q.rkhash & HMask) != k_hash)
                                                          rc_err = arc_pkg::ERR_KEY;
    else if (32'(s2_q.rslot) != 32'(s2_q.slot))          rc_err = arc_pkg::ERR_ACCT;
    else if (!valid_q[s_slot])                           rc_err = arc_pkg::ERR_NOCKPT;
    else if (s2_q.seq != e_seq)                          rc_err = arc_pkg::ERR_SEQ;
    else if ((s2_q.pre & HMask) != 64'(e_hash))          rc_err = arc_pkg::ERR_PRE;
    else if (s2_q.st <= e_end || s2_q.en < s2_q.st)      rc_err = arc_pkg::ERR_TIME;
    else                                                  rc_err = arc_pkg::ERR_NONE;
  end

  // Next set state and memory write from stage two
  logic [ACCOUNT_SLOTS-1:0] valid_d, hole_d;
  logic [63:0]      prev_lt_d, prev_hash_d;
  logic             have_prev_d, ofault_d, take, live;
  logic [CntW-1:0]  items_d, verified_d;
  logic [15:0]      ofault_idx_d, ferr_idx_d;
  arc_pkg::err_e    ferr_d, err;

  always_comb begin
    valid_d = valid_q; hole_d = hole_q;
    prev_lt_d = prev_lt_q; prev_hash_d = prev_hash_q; have_prev_d = have_prev_q;
    items_d = items_q; verified_d = verified_q;
    ofault_d = ofault_q; ofault_idx_d = ofault_idx_q;
    ferr_d = ferr_q; ferr_idx_d = ferr_idx_q;
    mem_we = 1'b0; mem_waddr = s_slot; mem_wdata = '0;
    err = arc_pkg::ERR_NONE; take = 1'b0; live = 1'b0;
    if (s2_vld_q) begin
      unique case (arc_pkg::op_e'(s2_q.op))
        arc_pkg::OP_BEGIN: begin
          valid_d = '0; hole_d = '0; prev_lt_d = '0; prev_hash_d = '0;
          have_prev_d = 1'b0; items_d = '0; verified_d = '0; ofault_d = 1'b0;
          ofault_idx_d = '0; ferr_d = arc_pkg::ERR_NONE; ferr_idx_d = '0;
        end
        arc_pkg::OP_LOAD: begin
          if (s_in_rng) begin
            valid_d[s_slot] = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = {s2_q.pre[HASH_BITS-1:0], s2_q.seq, s2_q.en};
          end
        end
        default: begin
          take = items_q < CntW'(MAX_ITEMS);
        end
      endcase
    end
    if (take) begin
      items_d = items_q + 1'b1;
      if (have_prev_q && !ofault_q &&
          !(prev_lt_q < s2_q.klt || (prev_lt_q == s2_q.klt && prev_hash_q < k_hash))) begin
        ofault_d = 1'b1;
        ofault_idx_d = 16'(items_q);
      end
      prev_lt_d = s2_q.klt; prev_hash_d = k_hash; have_prev_d = 1'b1;
      live = !ofault_d && ferr_q == arc_pkg::ERR_NONE;
      if (live) begin
        if (!s_in_rng) begin
          if (s2_q.op == arc_pkg::OP_RCPT) err = arc_pkg::ERR_COORD;
        end else if (s2_q.op == arc_pkg::OP_ITEM) begin
          hole_d[s_slot] = 1'b1;
        end else begin
          err = rc_err;
          if (rc_err == arc_pkg::ERR_NONE) begin
            mem_we     = 1'b1;
            mem_wdata  = {s2_q.post[HASH_BITS-1:0], e_seq + 32'd1, s2_q.en};
            verified_d = verified_q + 1'b1;
          end
        end
        if (err != arc_pkg::ERR_NONE) begin
          ferr_d = err; ferr_idx_d = 16'(items_q);
        end
      end
    end
    // Result for this beat
    if (ofault_d) res = {1'b1, 17'd0, ofault_idx_d, arc_pkg::ERR_ORDER};
    else res = {ferr_d != arc_pkg::ERR_NONE, 17'(verified_d), ferr_idx_d, ferr_d};
  end

  // Stage registers and set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0; fwd_q <= 1'b0; oq_cnt_q <= '0;
      valid_q <= '0; hole_q <= '0; prev_lt_q <= '0; prev_hash_q <= '0;
      have_prev_q <= 1'b0; items_q <= '0; verified_q <= '0;
      ofault_q <= 1'b0; ofault_idx_q <= '0;
      ferr_q <= arc_pkg::ERR_NONE; ferr_idx_q <= '0;
    end else begin
      s2_vld_q <= in_fire;
      fwd_q    <= in_fire && mem_we && mem_waddr == SlotW'(in_b.slot);
      oq_cnt_q <= oq_cnt_q + {1'b0, s2_vld_q} - {1'b0, out_fire};
      valid_q <= valid_d; hole_q <= hole_d;
      prev_lt_q <= prev_lt_d; prev_hash_q <= prev_hash_d; have_prev_q <= have_prev_d;
      items_q <= items_d; verified_q <= verified_d;
      ofault_q <= ofault_d; ofault_idx_q <= ofault_idx_d;
      ferr_q <= ferr_d; ferr_idx_q <= ferr_idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) s2_q <= in_b;
    fwd_data_q <= mem_wdata;
    if (s2_vld_q && (oq_cnt_q == 2'd0 || (oq_cnt_q == 2'd1 && out_fire))) oq_q[0] <= res;
    else if (out_fire) oq_q[0] <= oq_q[1];
    if (s2_vld_q && oq_cnt_q != 2'd0 && !(oq_cnt_q == 2'd1 && out_fire)) oq_q[1] <= res;
  end

  `ARC_ASSERT_IMP(a_oq_bound, clk_i, rst_ni, 1'b1, oq_cnt_q + {1'b0, s2_vld_q} <= 2'd2,
    "output queue overflow")
  `ARC_ASSERT_NXT(a_ofault_sticky, clk_i, rst_ni,
    ofault_q && !(s2_vld_q && s2_q.op == arc_pkg::OP_BEGIN), ofault_q,
    "order fault dropped without begin")
  `ARC_ASSERT_IMP(a_verified_le_items, clk_i, rst_ni, 1'b1, verified_q <= items_q,
    "more receipts verified than items")
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the account receipt checker unit.
`timescale 1ns / 1ps

module tb_top;
  localparam int unsigned Slots     = 64;
  localparam int unsigned ItemLimit = 65536;
  localparam int unsigned Watchdog  = 4000;
  localparam int unsigned RunItems  = 800;

  // One input beat, first field in the lowest bits.
  typedef struct packed {
    logic           pad;
    logic [63:0]    end_lt;
    logic [63:0]    start_lt;
    logic [63:0]    post_hash;
    logic [63:0]    pre_hash;
    logic [31:0]    seq;
    logic [5:0]     rslot;
    logic [63:0]    rkey_hash;
    logic [63:0]    rkey_lt;
    logic [6:0]     slot;
    logic [63:0]    key_hash;
    logic [63:0]    key_lt;
    arc_pkg::op_e   op;
  } beat_in_t;

  // One status beat.
  typedef struct packed {
    logic [1:0]     pad;
    logic           failed;
    logic [16:0]    verified;
    logic [15:0]    index;
    arc_pkg::err_e  code;
  } status_t;

  // Checkpoint table mirror and status predictor.
  class receipt_scoreboard;
    bit            valid[Slots];
    bit            hole[Slots];
    logic [63:0]   st_hash[Slots];
    logic [31:0]   nseq[Slots];
    logic [63:0]   last_end[Slots];
    logic [63:0]   prev_lt, prev_hash;
    bit            have_prev, ofault;
    int unsigned   items, verified, ofault_idx, err_idx;
    arc_pkg::err_e err;
    status_t       pending[$];
    int            mismatches;
    int            checked;

    function void clear_set();
      for (int i = 0; i < Slots; i++) begin
        valid[i] = 0;
        hole[i] = 0;
      end
      prev_lt = '0; prev_hash = '0; have_prev = 0; ofault = 0;
      items = 0; verified = 0; ofault_idx = 0; err_idx = 0; err = arc_pkg::ERR_NONE;
    endfunction

    function new();
      for (int i = 0; i < Slots; i++) begin
        st_hash[i] = '0; nseq[i] = '0; last_end[i] = '0;
      end
      clear_set();
      mismatches = 0;
      checked = 0;
    endfunction

    function arc_pkg::err_e verify_receipt(int unsigned s, beat_in_t b);
      if (hole[s]) return arc_pkg::ERR_HOLE;
      if (b.rkey_lt != b.key_lt || b.rkey_hash != b.key_hash) return arc_pkg::ERR_KEY;
      if (b.rslot != s[5:0]) return arc_pkg::ERR_ACCT;
      if (!valid[s]) return arc_pkg::ERR_NOCKPT;
      if (b.seq != nseq[s]) return arc_pkg::ERR_SEQ;
      if (b.pre_hash != st_hash[s]) return arc_pkg::ERR_PRE;
      if (b.start_lt <= last_end[s] || b.end_lt < b.start_lt) return arc_pkg::ERR_TIME;
      st_hash[s] = b.post_hash;
      nseq[s] = nseq[s] + 32'd1;
      last_end[s] = b.end_lt;
      verified++;
      return arc_pkg::ERR_NONE;
    endfunction

    function void take_item(beat_in_t b);
      int unsigned   idx;
      arc_pkg::err_e e;
      idx = items;
      e = arc_pkg::ERR_NONE;
      if (items >= ItemLimit) return;
      items++;
      if (have_prev && !ofault) begin
        if (!(prev_lt < b.key_lt || (prev_lt == b.key_lt && prev_hash < b.key_hash))) begin
          ofault = 1;
          ofault_idx = idx;
        end
      end
      prev_lt = b.key_lt;
      prev_hash = b.key_hash;
      have_prev = 1;
      if (ofault || err != arc_pkg::ERR_NONE) return;
      if (b.slot >= Slots) begin
        if (b.op == arc_pkg::OP_RCPT) e = arc_pkg::ERR_COORD;
      end else if (b.op == arc_pkg::OP_ITEM) begin
        hole[b.slot] = 1;
      end else begin
        e = verify_receipt(b.slot, b);
      end
      if (e != arc_pkg::ERR_NONE) begin
        err = e;
        err_idx = idx;
      end
    endfunction

    // Advance the model by one accepted beat and queue its status.
    function void note_input(beat_in_t b);
      status_t r;
      case (b.op)
        arc_pkg::OP_BEGIN: clear_set();
        arc_pkg::OP_LOAD: begin
          if (b.slot < Slots) begin
            valid[b.slot] = 1;
            st_hash[b.slot] = b.pre_hash;
            nseq[b.slot] = b.seq;
            last_end[b.slot] = b.end_lt;
          end
        end
        default: take_item(b);
      endcase
      r = '0;
      if (ofault) begin
        r.code = arc_pkg::ERR_ORDER;
        r.index = ofault_idx[15:0];
        r.failed = 1;
      end else begin
        r.code = err;
        r.index = err_idx[15:0];
        r.verified = verified[16:0];
        r.failed = (err != arc_pkg::ERR_NONE);
      end
      pending = {pending, r};
    endfunction

    // Compare one status beat with the oldest expectation.
    function void check_result(status_t act);
      status_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected status beat %h", $time, act);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      if (act.code !== exp.code) begin
        $display("%0t: error_code exp %0d act %0d", $time, exp.code, act.code);
        mismatches++;
      end
      if (act.index !== exp.index) begin
        $display("%0t: error_index exp %0d act %0d", $time, exp.index, act.index);
        mismatches++;
      end
      if (act.verified !== exp.verified) begin
        $display("%0t: verified_count exp %0d act %0d", $time, exp.verified, act.verified);
        mismatches++;
      end
      if (act.failed !== exp.failed) begin
        $display("%0t: failed exp %0b act %0b", $time, exp.failed, act.failed);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk_i = 0;
  logic           rst_ni = 0;
  logic           s_axis_tvalid = 0;
  logic           s_axis_tready;
  logic [559:0]   s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 0;
  logic [39:0]    m_axis_tdata;

  receipt_scoreboard sb = new();
  bit             quiet_in, quiet_out;
  int unsigned    stall_left;
  int unsigned    idle_cycles;
  int unsigned    sent_beats;
  logic [63:0]    cur_lt, cur_hash;

  always #1 clk_i = ~clk_i;

  account_receipt_checker_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic beat_in_t blank(arc_pkg::op_e op);
    beat_in_t b;
    b = '0;
    b.op = op;
    return b;
  endfunction

  // Drive one beat; hold valid high across back-to-back beats.
  task automatic send(beat_in_t b);
    int unsigned gap;
    gap = draw_wait(quiet_in);
    if ($urandom_range(0, 49) == 0) quiet_in = ~quiet_in;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(b);
    sent_beats++;
  endtask

  task automatic load(int unsigned s, logic [31:0] seq, logic [63:0] h, logic [63:0] e);
    beat_in_t b;
    b = blank(arc_pkg::OP_LOAD);
    b.slot = s[6:0];
    b.seq = seq;
    b.pre_hash = h;
    b.end_lt = e;
    b.rkey_lt = rand64();
    b.post_hash = rand64();
    send(b);
  endtask

  // Build a receipt that passes against the current checkpoint of a slot.
  function automatic beat_in_t good_receipt(int unsigned s, logic [63:0] klt, logic [63:0] kh);
    beat_in_t b;
    b = blank(arc_pkg::OP_RCPT);
    b.key_lt = klt;
    b.key_hash = kh;
    b.slot = s[6:0];
    b.rkey_lt = klt;
    b.rkey_hash = kh;
    b.rslot = s[5:0];
    b.seq = sb.nseq[s];
    b.pre_hash = sb.st_hash[s];
    b.post_hash = rand64();
    b.start_lt = sb.last_end[s] + 64'($urandom_range(1, 50));
    b.end_lt = b.start_lt + 64'($urandom_range(0, 50));
    return b;
  endfunction

  // Open a set with a fresh slot 5 checkpoint for the single-error cases.
  task automatic fresh_set();
    send(blank(arc_pkg::OP_BEGIN));
    load(5, 32'd100, 64'hA5A5_0000_0000_5A5A, 64'd1000);
  endtask

  task automatic directed();
    beat_in_t b;
    // Extremes, sequence wrap, ignored load, hole
    send(blank(arc_pkg::OP_BEGIN));
    load(0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    load(63, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFF0);
    load(64, 32'd7, 64'd7, 64'd7);
    send(good_receipt(0, 64'd0, 64'd0));
    send(good_receipt(0, 64'd0, 64'd1));
    b = blank(arc_pkg::OP_ITEM);
    b.key_lt = 64'd5; b.slot = 7'd63;
    send(b);
    b = good_receipt(63, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(b);
    // Coordinator item with a receipt
    fresh_set();
    b = blank(arc_pkg::OP_ITEM); b.slot = 7'd64; b.key_lt = 64'd1;
    send(b);
    b = blank(arc_pkg::OP_RCPT); b.slot = 7'd64; b.key_lt = 64'd2;
    send(b);
    // Key, account, no checkpoint, sequence, prestate, time mismatches
    for (int k = 0; k < 6; k++) begin
      fresh_set();
      b = good_receipt(5, 64'd10, 64'd3);
      case (k)
        0: b.rkey_hash = 64'd4;
        1: b.rslot = 6'd6;
        2: begin b.slot = 7'd9; b.rslot = 6'd9; end
        3: b.seq = 32'd101;
        4: b.pre_hash = 64'd0;
        default: b.start_lt = 64'd1000;
      endcase
      send(b);
    end
    // Ordering fault after a verified receipt, then a later load
    fresh_set();
    send(good_receipt(5, 64'd20, 64'd0));
    b = blank(arc_pkg::OP_ITEM); b.key_lt = 64'd20; b.slot = 7'd64;
    send(b);
    load(5, 32'd0, 64'd0, 64'd0);
    send(good_receipt(5, 64'd30, 64'd0));
  endtask

  // Step the item key forward, rarely repeating or reversing it.
  task automatic next_key();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r < 2) begin
      cur_lt = cur_lt - 64'($urandom_range(0, 1));
    end else if (r < 30 && cur_hash != '1) begin
      cur_hash = cur_hash + 64'($urandom_range(1, 9));
    end else begin
      cur_lt = cur_lt + 64'($urandom_range(1, 1000));
      cur_hash = rand64();
    end
  endtask

  task automatic random_set(int unsigned n);
    beat_in_t    b;
    int unsigned s, r;
    send(blank(arc_pkg::OP_BEGIN));
    cur_lt = ($urandom_range(0, 9) == 0) ? 64'hFFFF_FFFF_FFFF_0000 : (rand64() >> 1);
    cur_hash = rand64();
    repeat ($urandom_range(2, 8)) begin
      s = $urandom_range(0, 7);
      load(s, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFE : $urandom, rand64(),
           ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 999)));
    end
    repeat (n) begin
      next_key();
      s = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        load($urandom_range(0, 80), $urandom, rand64(), 64'($urandom));
      end else if (r < 10) begin
        b = blank(arc_pkg::OP_ITEM); b.key_lt = cur_lt; b.key_hash = cur_hash;
        b.slot = 7'd64;
        send(b);
      end else if (r < 12) begin
        b = blank(arc_pkg::OP_RCPT); b.key_lt = cur_lt; b.key_hash = cur_hash;
        b.slot = 7'($urandom_range(64, 127));
        send(b);
      end else if (r < 17) begin
        b = blank(arc_pkg::OP_ITEM); b.key_lt = cur_lt; b.key_hash = cur_hash;
        b.slot = s[6:0];
        send(b);
      end else begin
        b = good_receipt(s, cur_lt, cur_hash);
        if ($urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 5))
            0: b.rkey_lt = rand64();
            1: b.rslot = 6'($urandom);
            2: b.seq = $urandom;
            3: b.pre_hash = rand64();
            4: b.start_lt = sb.last_end[s];
            default: b.end_lt = b.start_lt - 64'd1;
          endcase
        end
        send(b);
      end
    end
  endtask

  // Receiver side: accept, check, then stall for a drawn count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        stall_left = draw_wait(quiet_out);
        if ($urandom_range(0, 49) == 0) quiet_out = ~quiet_out;
        m_axis_tready <= (stall_left == 0);
      end else if (!m_axis_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  // Stop the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= Watchdog) begin
      $display("watchdog expired with %0d results pending", sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    quiet_in = 0;
    quiet_out = 0;
    stall_left = 0;
    idle_cycles = 0;
    sent_beats = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    m_axis_tready <= 1'b1;
    @(posedge clk_i);
    directed();
    while (sent_beats < RunItems) begin
      random_set($urandom_range(10, 50));
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("checked %0d status beats over directed cases and random sets", sb.checked);
    $display("mismatches: %0d, leftover expectations: %0d", sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- account_receipt_checker_unit.f -----
+incdir+rtl
rtl/arc_pkg.sv
rtl/arc_slot_mem.sv
rtl/account_receipt_checker_unit.sv
test/tb_top.sv
